[design/dtq_pkg.sv]
`timescale 1ns / 1ps

package dtq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int TIME_W      = 64;
    localparam int DELAY_W     = 48;
    localparam int HANDLE_W    = 32;
    localparam int STATUS_W    = 3;

    // operation codes
    localparam logic FUNC_SUBMIT = 1'b0;
    localparam logic FUNC_FETCH  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUE      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WAITING  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic                func;
        logic [TIME_W-1:0]   now_time;
        logic [DELAY_W-1:0]  delay_ns;
        logic [HANDLE_W-1:0] task_handle;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] due_handle;
        logic [TIME_W-1:0]   next_deadline;
        logic                wake;
    } rsp_t;

    typedef struct packed {
        logic [TIME_W-1:0]   deadline;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    // now + delay, clamped at the top of the time range
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] now,
                                                  input logic [DELAY_W-1:0] delay);
        logic [TIME_W:0] sum;
        sum = {1'b0, now} + {{(TIME_W - DELAY_W + 1){1'b0}}, delay};
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

endpackage

[design/dtq_mem.sv]
`timescale 1ns / 1ps

module dtq_mem #(
    parameter int DEPTH = dtq_pkg::QUEUE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  dtq_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output dtq_pkg::entry_t rdata
);

    dtq_pkg::entry_t mem [DEPTH];
    dtq_pkg::entry_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/dtq_ctrl.sv]
`timescale 1ns / 1ps

module dtq_ctrl #(
    parameter int DEPTH = dtq_pkg::QUEUE_DEPTH,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  dtq_pkg::req_t   in_req,
    input  logic            out_free,
    output logic            res_valid,
    output dtq_pkg::rsp_t   res,
    output logic            mem_we,
    output logic [AW-1:0]   mem_waddr,
    output dtq_pkg::entry_t mem_wdata,
    output logic [AW-1:0]   mem_raddr,
    input  dtq_pkg::entry_t mem_rdata
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_PUTF = 5'b00100,
        S_FCHK = 5'b01000,
        S_RESP = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [AW-1:0]                   head_reg, head_next;
    logic [CW-1:0]                   occ_reg, occ_next;
    logic [AW-1:0]                   idx_reg, idx_next;
    logic [dtq_pkg::TIME_W-1:0]      dl_reg, dl_next;
    logic [dtq_pkg::TIME_W-1:0]      now_reg, now_next;
    logic [dtq_pkg::HANDLE_W-1:0]    hdl_reg, hdl_next;
    dtq_pkg::rsp_t                   res_reg, res_next;
    logic [AW-1:0]                   occ_m1;
    logic                            due;

    // ring position: base + offset, wrapped at the depth
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= (AW+1)'(DEPTH))
        begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign occ_m1    = occ_reg[AW-1:0] - 1'b1;
    assign due       = (mem_rdata.deadline <= now_reg);
    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_RESP) && out_free;
    assign res       = res_reg;

    // sequence one request: scan the sorted ring from the tail, or check the head
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        occ_next   = occ_reg;
        idx_next   = idx_reg;
        dl_next    = dl_reg;
        now_next   = now_reg;
        hdl_next   = hdl_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = head_reg;
        mem_wdata  = '{deadline: dl_reg, handle: hdl_reg};
        mem_raddr  = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_req.func == dtq_pkg::FUNC_SUBMIT && occ_reg != '0)
                begin
                    mem_raddr = slot(head_reg, occ_m1);
                end
                if (in_valid)
                begin
                    dl_next  = dtq_pkg::sat_add(in_req.now_time, in_req.delay_ns);
                    now_next = in_req.now_time;
                    hdl_next = in_req.task_handle;
                    res_next = '0;
                    if (in_req.func == dtq_pkg::FUNC_SUBMIT)
                    begin
                        if (occ_reg == CW'(DEPTH))
                        begin
                            res_next.status = dtq_pkg::ST_FULL;
                            state_next      = S_RESP;
                        end
                        else if (occ_reg == '0)
                        begin
                            mem_we          = 1'b1;
                            mem_waddr       = head_reg;
                            mem_wdata       = '{deadline: dl_next, handle: hdl_next};
                            occ_next        = occ_reg + 1'b1;
                            res_next.status = dtq_pkg::ST_ACCEPTED;
                            res_next.wake   = 1'b1;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            idx_next   = occ_m1;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (occ_reg == '0)
                        begin
                            res_next.status = dtq_pkg::ST_EMPTY;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            state_next = S_FCHK;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                res_next.status = dtq_pkg::ST_ACCEPTED;
                if (idx_reg != '0)
                begin
                    mem_raddr = slot(head_reg, idx_reg - 1'b1);
                end
                mem_we    = 1'b1;
                mem_waddr = slot(head_reg, idx_reg + 1'b1);
                if (mem_rdata.deadline >= dl_reg)
                begin
                    // shift this entry one place toward the tail
                    mem_wdata = mem_rdata;
                    if (idx_reg == '0)
                    begin
                        res_next.wake = (mem_rdata.deadline > dl_reg);
                        state_next    = S_PUTF;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
                else
                begin
                    // drop the new entry in the gap
                    occ_next      = occ_reg + 1'b1;
                    res_next.wake = 1'b0;
                    state_next    = S_RESP;
                end
            end

            S_PUTF:
            begin
                mem_we     = 1'b1;
                mem_waddr  = head_reg;
                occ_next   = occ_reg + 1'b1;
                state_next = S_RESP;
            end

            S_FCHK:
            begin
                res_next = '0;
                if (due)
                begin
                    res_next.status     = dtq_pkg::ST_DUE;
                    res_next.due_handle = mem_rdata.handle;
                    head_next           = slot(head_reg, AW'(1));
                    occ_next            = occ_reg - 1'b1;
                end
                else
                begin
                    res_next.status        = dtq_pkg::ST_WAITING;
                    res_next.next_deadline = mem_rdata.deadline;
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            occ_reg   <= occ_next;
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        dl_reg  <= dl_next;
        now_reg <= now_next;
        hdl_reg <= hdl_next;
        res_reg <= res_next;
    end

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < AW'(DEPTH - 1) || head_reg == AW'(DEPTH - 1))
        else $error("head pointer out of range");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FCHK && due) |=> occ_reg == $past(occ_reg) - 1'b1)
        else $error("pop did not reduce occupancy");
`endif

endmodule

[design/deadline_task_queue.sv]
`timescale 1ns / 1ps
// Requests are handled one at a time (in_stall is high outside idle). A full reject, an
// empty fetch or a submit to an empty queue goes straight to the response; a fetch first
// checks the head; other submits scan from the tail, shifting each entry with a later or
// equal deadline one slot. The next request is taken once the result is registered.
// Reset (rst_n, async low) empties the queue; the memory itself is not cleared.
module deadline_task_queue #(
    parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  dtq_pkg::req_t in_req,
    output logic          out_valid,
    input  logic          out_stall,
    output dtq_pkg::rsp_t out_rsp
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic            out_valid_reg;
    dtq_pkg::rsp_t   out_rsp_reg;
    logic            out_free;
    logic            res_valid;
    dtq_pkg::rsp_t   res;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr;
    dtq_pkg::entry_t mem_wdata;
    dtq_pkg::entry_t mem_rdata;

    assign out_free = !out_valid_reg || !out_stall;

    dtq_ctrl #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    dtq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // hold the result until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_rsp_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

endmodule

[bench/deadline_task_queue_test.sv]
`timescale 1ns / 1ps

module deadline_task_queue_test;

    localparam int WATCH_LIMIT = 20000;
    localparam int RANDOM_REQS = 1510;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    dtq_pkg::req_t in_req;
    logic          out_valid;
    logic          out_stall;
    dtq_pkg::rsp_t out_rsp;

    deadline_task_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rsp   (out_rsp)
    );

    // shadow of the sorted queue
    logic [dtq_pkg::TIME_W-1:0]   shadow_deadline [dtq_pkg::QUEUE_DEPTH];
    logic [dtq_pkg::HANDLE_W-1:0] shadow_handle [dtq_pkg::QUEUE_DEPTH];
    int                           shadow_count;

    dtq_pkg::rsp_t pending_rsp[$];
    int   error_count;
    int   rsp_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   idle_cycles;
    int   due_seen;
    int   full_seen;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("mismatch on response %0d: %s got %0h expected %0h",
                 rsp_count, what, got, want);
    endtask

    // compute the response for one request and update the shadow queue
    function automatic dtq_pkg::rsp_t predict_queue(input dtq_pkg::req_t r);
        dtq_pkg::rsp_t              res;
        logic [dtq_pkg::TIME_W:0]   sum;
        logic [dtq_pkg::TIME_W-1:0] dl;
        int                         pos;
        res = '0;
        if (r.func == dtq_pkg::FUNC_SUBMIT)
        begin
            if (shadow_count >= dtq_pkg::QUEUE_DEPTH)
            begin
                res.status = dtq_pkg::ST_FULL;
                return res;
            end
            sum = {1'b0, r.now_time} + {17'd0, r.delay_ns};
            dl = sum[dtq_pkg::TIME_W] ? {dtq_pkg::TIME_W{1'b1}} : sum[dtq_pkg::TIME_W-1:0];
            res.status = dtq_pkg::ST_ACCEPTED;
            res.wake = (shadow_count == 0) || (dl < shadow_deadline[0]);
            pos = 0;
            while (pos < shadow_count && shadow_deadline[pos] < dl)
                pos++;
            for (int i = shadow_count; i > pos; i--)
            begin
                shadow_deadline[i] = shadow_deadline[i-1];
                shadow_handle[i] = shadow_handle[i-1];
            end
            shadow_deadline[pos] = dl;
            shadow_handle[pos] = r.task_handle;
            shadow_count++;
        end
        else if (shadow_count == 0)
            res.status = dtq_pkg::ST_EMPTY;
        else if (shadow_deadline[0] > r.now_time)
        begin
            res.status = dtq_pkg::ST_WAITING;
            res.next_deadline = shadow_deadline[0];
        end
        else
        begin
            res.status = dtq_pkg::ST_DUE;
            res.due_handle = shadow_handle[0];
            for (int i = 1; i < shadow_count; i++)
            begin
                shadow_deadline[i-1] = shadow_deadline[i];
                shadow_handle[i-1] = shadow_handle[i];
            end
            shadow_count--;
        end
        return res;
    endfunction

    // check responses and drive the receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        dtq_pkg::rsp_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                rsp_count++;
                if (pending_rsp.size() == 0)
                begin
                    error_count++;
                    $display("unexpected response %0d", rsp_count);
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (out_rsp.status != want.status)
                        report_mismatch("status", 64'(out_rsp.status), 64'(want.status));
                    if (out_rsp.due_handle != want.due_handle)
                        report_mismatch("due_handle", 64'(out_rsp.due_handle),
                                        64'(want.due_handle));
                    if (out_rsp.next_deadline != want.next_deadline)
                        report_mismatch("next_deadline", out_rsp.next_deadline,
                                        want.next_deadline);
                    if (out_rsp.wake != want.wake)
                        report_mismatch("wake", 64'(out_rsp.wake), 64'(want.wake));
                    if (out_rsp.status == dtq_pkg::ST_DUE)
                        due_seen++;
                    if (out_rsp.status == dtq_pkg::ST_FULL)
                        full_seen++;
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("timeout waiting for a handshake");
            $display("*** FAILED ***");
            $finish;
        end
    end

    // drive one request; expectation is taken at acceptance
    task automatic send_req(input dtq_pkg::req_t r, input bit has_want,
                            input dtq_pkg::rsp_t want);
        dtq_pkg::rsp_t got;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        got = predict_queue(r);
        if (has_want && got != want)
        begin
            error_count++;
            $display("directed row disagrees with prediction for func %0d", r.func);
        end
        pending_rsp.push_back(got);
    endtask

    // drop valid and wait for every expected response
    task automatic drain_all();
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    function automatic dtq_pkg::req_t make_req(input logic f, input logic [63:0] t,
                                               input logic [47:0] d, input logic [31:0] h);
        dtq_pkg::req_t r;
        r.func = f;
        r.now_time = t;
        r.delay_ns = d;
        r.task_handle = h;
        return r;
    endfunction

    function automatic dtq_pkg::rsp_t make_rsp(input logic [2:0] s, input logic [31:0] h,
                                               input logic [63:0] n, input logic w);
        dtq_pkg::rsp_t x;
        x.status = s;
        x.due_handle = h;
        x.next_deadline = n;
        x.wake = w;
        return x;
    endfunction

    typedef struct {
        dtq_pkg::req_t r;
        bit            known;
        dtq_pkg::rsp_t want;
    } row_t;

    row_t directed[$];
    logic [63:0] clock_now;

    // random request with a time base that mostly advances
    function automatic dtq_pkg::req_t random_req();
        logic [63:0] t;
        logic [47:0] d;
        int sel;
        sel = $urandom_range(99);
        if (sel < 85)
        begin
            clock_now = clock_now + $urandom_range(60);
            t = clock_now;
        end
        else
            t = {$urandom, $urandom};
        sel = $urandom_range(99);
        if (sel < 70)
            d = 48'($urandom_range(100));
        else if (sel < 80)
            d = '0;
        else if (sel < 90)
            d = 48'({$urandom, $urandom});
        else
            d = '1;
        return make_req($urandom_range(99) < 50 ? dtq_pkg::FUNC_FETCH : dtq_pkg::FUNC_SUBMIT,
                        t, d, $urandom);
    endfunction

    initial
    begin
        dtq_pkg::rsp_t none;
        error_count = 0;
        rsp_count = 0;
        due_seen = 0;
        full_seen = 0;
        shadow_count = 0;
        clock_now = 64'd1000;
        send_idle_pct = 29;
        recv_idle_pct = 68;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_req = '0;
        none = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty, extremes, saturation, ties, due and waiting
        directed.push_back('{make_req(dtq_pkg::FUNC_FETCH, 64'd0, 48'd0, 32'd0), 1,
                             make_rsp(dtq_pkg::ST_EMPTY, 0, 0, 0)});
        directed.push_back('{make_req(dtq_pkg::FUNC_SUBMIT, '1, '1, '1), 1,
                             make_rsp(dtq_pkg::ST_ACCEPTED, 0, 0, 1)});
        directed.push_back('{make_req(dtq_pkg::FUNC_FETCH, 64'd5, 48'd0, 32'd0), 1,
                             make_rsp(dtq_pkg::ST_WAITING, 0, '1, 0)});
        directed.push_back('{make_req(dtq_pkg::FUNC_SUBMIT, 64'd100, 48'd50, 32'hA), 1,
                             make_rsp(dtq_pkg::ST_ACCEPTED, 0, 0, 1)});
        directed.push_back('{make_req(dtq_pkg::FUNC_SUBMIT, 64'd150, 48'd0, 32'hB), 1,
                             make_rsp(dtq_pkg::ST_ACCEPTED, 0, 0, 0)});
        directed.push_back('{make_req(dtq_pkg::FUNC_SUBMIT, 64'd200, 48'd10, 32'hC), 0,
                             none});
        directed.push_back('{make_req(dtq_pkg::FUNC_FETCH, 64'd149, 48'd0, 32'd0), 1,
                             make_rsp(dtq_pkg::ST_WAITING, 0, 64'd150, 0)});
        directed.push_back('{make_req(dtq_pkg::FUNC_FETCH, 64'd150, 48'd0, 32'd0), 1,
                             make_rsp(dtq_pkg::ST_DUE, 32'hB, 0, 0)});
        directed.push_back('{make_req(dtq_pkg::FUNC_FETCH, '1, '1, '1), 0, none});
        directed.push_back('{make_req(dtq_pkg::FUNC_SUBMIT, 64'h0, 48'h0, 32'h0), 0, none});
        directed.push_back('{make_req(dtq_pkg::FUNC_SUBMIT, 64'h5555_5555_5555_5555,
                             48'hAAAA_AAAA_AAAA, 32'h5555_5555), 0, none});
        directed.push_back('{make_req(dtq_pkg::FUNC_SUBMIT, 64'hAAAA_AAAA_AAAA_AAAA,
                             48'h5555_5555_5555, 32'hAAAA_AAAA), 0, none});
        foreach (directed[i])
            send_req(directed[i].r, directed[i].known, directed[i].want);

        // fill to capacity then overflow
        drain_all();
        while (shadow_count < dtq_pkg::QUEUE_DEPTH)
            send_req(make_req(dtq_pkg::FUNC_SUBMIT, 64'd10, 48'($urandom_range(30)),
                              $urandom), 0, none);
        send_req(make_req(dtq_pkg::FUNC_SUBMIT, 64'd10, 48'd1, 32'h1), 1,
                 make_rsp(dtq_pkg::ST_FULL, 0, 0, 0));
        while (shadow_count > 0)
            send_req(make_req(dtq_pkg::FUNC_FETCH, '1, 48'd0, 32'd0), 0, none);

        // random phases with changing idle patterns
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n == RANDOM_REQS / 3)
            begin
                drain_all();
                send_idle_pct = 68;
                recv_idle_pct = 29;
            end
            else if (n == 2 * RANDOM_REQS / 3)
            begin
                drain_all();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_req(random_req(), 0, none);
        end

        drain_all();
        repeat (100) @(posedge clk);
        $display("covered %0d responses: %0d due pops, %0d full rejects",
                 rsp_count, due_seen, full_seen);
        $display("directed extremes, saturation, ties, overflow and three idle patterns");
        if (error_count == 0 && pending_rsp.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
